// File: hdl/ppid_pkg.sv
`default_nettype none

package ppid_pkg;

  localparam int DataWidth     = 16;
  localparam int GainWidth     = 16;
  localparam int LimitWidth    = 15;
  localparam int WindowWidth   = 16;
  localparam int CfgDataWidth  = 16;
  localparam int CfgIndexWidth = 3;

  localparam int ErrWidth   = DataWidth + 1;
  localparam int DiffWidth  = DataWidth + 2;
  localparam int PropWidth  = GainWidth + ErrWidth + 1;
  localparam int DerivWidth = GainWidth + DiffWidth + 1;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;

  localparam cfg_index_t RegGainP    = 3'd0;
  localparam cfg_index_t RegGainI    = 3'd1;
  localparam cfg_index_t RegGainD    = 3'd2;
  localparam cfg_index_t RegDriveMax = 3'd3;
  localparam cfg_index_t RegDriveMin = 3'd4;
  localparam cfg_index_t RegWindup   = 3'd5;
  localparam cfg_index_t RegWindow   = 3'd6;

  localparam logic signed [DataWidth-1:0] DriveMaxReset = 16'sh7fff;
  localparam logic signed [DataWidth-1:0] DriveMinReset = 16'sh8000;
  localparam logic [LimitWidth-1:0]       WindupReset   = 15'd500;
  localparam logic [WindowWidth-1:0]      WindowReset   = 16'd50;

  typedef struct packed {
    logic signed [DataWidth-1:0] measured;
    logic signed [DataWidth-1:0] setpoint;
  } in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] drive;
    logic                        clipped;
  } out_t;

  typedef struct packed {
    logic [GainWidth-1:0]        gain_p;
    logic [GainWidth-1:0]        gain_i;
    logic [GainWidth-1:0]        gain_d;
    logic signed [DataWidth-1:0] drive_max;
    logic signed [DataWidth-1:0] drive_min;
    logic [LimitWidth-1:0]       windup_limit;
    logic [WindowWidth-1:0]      integrate_window;
  } cfg_t;

  typedef struct packed {
    logic signed [PropWidth-1:0]  p_term;
    logic signed [PropWidth-1:0]  i_term;
    logic signed [DerivWidth-1:0] d_term;
    logic                         in_window;
  } term_t;

endpackage

`default_nettype wire

// File: hdl/ppid_front.sv
`default_nettype none

module ppid_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire ppid_pkg::in_t  sample,
  input  wire ppid_pkg::cfg_t cfg,
  output ppid_pkg::term_t     term
);
  import ppid_pkg::*;

  localparam int CmpWidth = (ErrWidth > WindowWidth) ? ErrWidth : WindowWidth;

  logic signed [ErrWidth-1:0]  err;
  logic [ErrWidth-1:0]         mag;
  logic signed [ErrWidth-1:0]  previous_error;
  logic signed [DiffWidth-1:0] diff;
  logic signed [GainWidth:0]   kp;
  logic signed [GainWidth:0]   ki;
  logic signed [GainWidth:0]   kd;
  term_t                       term_next;

  assign err  = ErrWidth'(sample.setpoint) - ErrWidth'(sample.measured);
  assign mag  = err[ErrWidth-1] ? -err : err;
  assign diff = DiffWidth'(err) - DiffWidth'(previous_error);
  assign kp   = {1'b0, cfg.gain_p};
  assign ki   = {1'b0, cfg.gain_i};
  assign kd   = {1'b0, cfg.gain_d};

  always_comb begin
    term_next.p_term    = PropWidth'(kp) * PropWidth'(err);
    term_next.i_term    = PropWidth'(ki) * PropWidth'(err);
    term_next.d_term    = DerivWidth'(kd) * DerivWidth'(diff);
    term_next.in_window = CmpWidth'(mag) < CmpWidth'(cfg.integrate_window);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
    end else if (load) begin
      previous_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      term <= term_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ppid_back.sv
`default_nettype none

module ppid_back #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire ppid_pkg::term_t term,
  input  wire ppid_pkg::cfg_t  cfg,
  output ppid_pkg::out_t       result
);
  import ppid_pkg::*;

  localparam int LimW   = LimitWidth + GAIN_FRAC_BITS;
  localparam int IntW   = LimW + 1;
  localparam int AccW   = ((IntW > PropWidth) ? IntW : PropWidth) + 1;
  localparam int TermW  = (PropWidth > DerivWidth) ? PropWidth : DerivWidth;
  localparam int SumW   = ((TermW > IntW) ? TermW : IntW) + 2;

  logic signed [IntW-1:0] integral_sum;
  logic signed [IntW-1:0] integral_next;
  logic [LimW-1:0]        lim_mag;
  logic signed [AccW-1:0] lim_pos;
  logic signed [AccW-1:0] lim_neg;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] acc_clamped;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] shifted;
  logic signed [SumW-1:0] hi;
  logic signed [SumW-1:0] lo;
  out_t                   result_next;

  assign lim_mag = LimW'(cfg.windup_limit) << GAIN_FRAC_BITS;
  assign lim_pos = AccW'(lim_mag);
  assign lim_neg = -lim_pos;
  assign acc     = AccW'(integral_sum) + AccW'(term.i_term);

  always_comb begin
    if (acc > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc;
    end
    integral_next = term.in_window ? IntW'(acc_clamped) : integral_sum;
  end

  assign sum     = SumW'(term.p_term) + SumW'(integral_next) + SumW'(term.d_term);
  assign shifted = sum >>> GAIN_FRAC_BITS;
  assign hi      = SumW'(cfg.drive_max);
  assign lo      = SumW'(cfg.drive_min);

  always_comb begin
    if (shifted > hi) begin
      result_next.drive   = cfg.drive_max;
      result_next.clipped = 1'b1;
    end else if (shifted < lo) begin
      result_next.drive   = cfg.drive_min;
      result_next.clipped = 1'b1;
    end else begin
      result_next.drive   = DataWidth'(shifted);
      result_next.clipped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else if (load) begin
      integral_sum <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/positional_pid_with_anti_windup.sv
// path: a request goes through the request, front term and back result registers
// throughput: one request per cycle, set by the integral update being registered
//   once per request in the back stage; a stalled output holds the pipeline
// reset: clears the pipeline, the previous error and the integral, and puts
//   the gains to zero and the bounds, limit and window to their defaults
`default_nettype none

module positional_pid_with_anti_windup #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire ppid_pkg::in_t                         in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output ppid_pkg::out_t                             out_data,
  input  wire logic                                  cfg_write,
  input  wire logic [ppid_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  wire logic [ppid_pkg::CfgDataWidth-1:0]     cfg_data
);
  import ppid_pkg::*;

  cfg_t  cfg;
  in_t   sample;
  term_t term;
  logic  a_valid;
  logic  b_valid;
  logic  a_load;
  logic  b_load;
  logic  out_load;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p           <= '0;
      cfg.gain_i           <= '0;
      cfg.gain_d           <= '0;
      cfg.drive_max        <= DriveMaxReset;
      cfg.drive_min        <= DriveMinReset;
      cfg.windup_limit     <= WindupReset;
      cfg.integrate_window <= WindowReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegGainP:    cfg.gain_p           <= GainWidth'(cfg_data);
        RegGainI:    cfg.gain_i           <= GainWidth'(cfg_data);
        RegGainD:    cfg.gain_d           <= GainWidth'(cfg_data);
        RegDriveMax: cfg.drive_max        <= DataWidth'(cfg_data);
        RegDriveMin: cfg.drive_min        <= DataWidth'(cfg_data);
        RegWindup:   cfg.windup_limit     <= LimitWidth'(cfg_data);
        RegWindow:   cfg.integrate_window <= WindowWidth'(cfg_data);
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign out_load = b_valid && (!out_valid || !out_stall);
  assign b_load   = a_valid && (!b_valid || out_load);
  assign in_stall = a_valid && !b_load;
  assign a_load   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
      if (b_load) begin
        b_valid <= 1'b1;
      end else if (out_load) begin
        b_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (a_load) begin
      sample <= in_data;
    end
  end

  ppid_front u_front (
    .clk    (clk),
    .rst    (rst),
    .load   (b_load),
    .sample (sample),
    .cfg    (cfg),
    .term   (term)
  );

  ppid_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .load   (out_load),
    .term   (term),
    .cfg    (cfg),
    .result (out_data)
  );

`ifndef SYNTHESIS
  a_clip_at_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clipped |->
      (out_data.drive == cfg.drive_max) || (out_data.drive == cfg.drive_min))
    else $error("clipped drive is not at a bound");

  a_unclipped_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.clipped |->
      (out_data.drive <= cfg.drive_max) && (out_data.drive >= cfg.drive_min))
    else $error("unclipped drive outside bounds");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid && b_valid && out_valid && out_stall)
    else $error("request stalled with room in the pipeline");

  a_mid_stage_held: assert property (@(posedge clk) disable iff (rst)
    b_valid && out_valid && out_stall |=> b_valid)
    else $error("middle stage dropped a request under stall");
`endif

endmodule

`default_nettype wire
